/* sv/gipps_car_following_accel_macros.svh */
// Assertion helpers for the checker file.
`ifndef GIPPS_CAR_FOLLOWING_ACCEL_MACROS_SVH
`define GIPPS_CAR_FOLLOWING_ACCEL_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define GCFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also runs during reset.
`define GCFA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/gcfa_pkg.sv */
package gcfa_pkg;

  localparam int unsigned FRAC_BITS_DEF = 10;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam logic [32:0] Q16_0025      = 33'd1638;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ACCEL     = 3'd0,
    CFG_MAX_DECEL     = 3'd1,
    CFG_DESIRED_SPEED = 3'd2,
    CFG_REACTION_TIME = 3'd3,
    CFG_STANDSTILL    = 3'd4,
    CFG_LEADER_DECEL  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [13:0]        max_accel;
    logic signed [14:0] max_decel;
    logic [15:0]        desired_speed;
    logic [11:0]        reaction_time;
    logic [15:0]        standstill_spacing;
    logic signed [14:0] leader_decel_estimate;
  } cfg_t;

  localparam logic [13:0]        RST_MAX_ACCEL     = 14'd2048;
  localparam logic signed [14:0] RST_MAX_DECEL     = -15'sd3072;
  localparam logic [15:0]        RST_DESIRED_SPEED = 16'd20480;
  localparam logic [11:0]        RST_REACTION_TIME = 12'd717;
  localparam logic [15:0]        RST_STANDSTILL    = 16'd6656;
  localparam logic signed [14:0] RST_LEADER_DECEL  = -15'sd2560;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    priority if (x > 64'sd32767) begin
      return 16'sh7fff;
    end else if (x < -64'sd32768) begin
      return 16'sh8000;
    end else begin
      return x[15:0];
    end
  endfunction

endpackage

/* sv/gcfa_fifo.sv */
module gcfa_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o,
  output logic         full_o
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [W-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0] cnt_q;
  logic do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i && (!full_o || do_pop);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
      if (do_pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + (AW+1)'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end
endmodule

/* sv/gcfa_div.sv */
module gcfa_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] dvd_i,
  input  logic [DW-1:0] dvs_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [TW-1:0] tag_o
);
  // one quotient bit per stage; dividend bits shift out the top of wk
  // while quotient bits shift in at the bottom
  logic          vld [NW+1];
  logic [NW-1:0] wk  [NW+1];
  logic [DW-1:0] rm  [NW+1];
  logic [DW-1:0] ds  [NW+1];
  logic [TW-1:0] tg  [NW+1];

  assign vld[0] = valid_i;
  assign wk[0]  = dvd_i;
  assign rm[0]  = '0;
  assign ds[0]  = dvs_i;
  assign tg[0]  = tag_i;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] part;
    logic [DW:0] diff;
    logic        ge;

    assign part = {rm[s], wk[s][NW-1]};
    assign diff = part - {1'b0, ds[s]};
    assign ge   = (part >= {1'b0, ds[s]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        wk[s+1] <= {wk[s][NW-2:0], ge};
        rm[s+1] <= ge ? diff[DW-1:0] : part[DW-1:0];
        ds[s+1] <= ds[s];
        tg[s+1] <= tg[s];
      end
    end
  end

  assign valid_o = vld[NW];
  assign quo_o   = wk[NW];
  assign rem_o   = rm[NW];
  assign tag_o   = tg[NW];
endmodule

/* sv/gcfa_sqrt.sv */
module gcfa_sqrt #(
  parameter int unsigned OW = 16,
  parameter int unsigned TW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*OW-1:0] rad_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [OW-1:0]   root_o,
  output logic [TW-1:0]   tag_o
);
  // floor square root, one result bit per stage
  logic            vld [OW+1];
  logic [2*OW-1:0] xs  [OW+1];
  logic [OW:0]     rm  [OW+1];
  logic [OW-1:0]   rt  [OW+1];
  logic [TW-1:0]   tg  [OW+1];

  assign vld[0] = valid_i;
  assign xs[0]  = rad_i;
  assign rm[0]  = '0;
  assign rt[0]  = '0;
  assign tg[0]  = tag_i;

  for (genvar s = 0; s < OW; s++) begin : g_stage
    logic [OW+2:0] part;
    logic [OW+2:0] trial;
    logic [OW+2:0] diff;
    logic          ge;

    assign part  = {rm[s], xs[s][2*OW-1 -: 2]};
    assign trial = {1'b0, rt[s], 2'b01};
    assign diff  = part - trial;
    assign ge    = (part >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xs[s+1] <= xs[s] << 2;
        rm[s+1] <= ge ? diff[OW:0] : part[OW:0];
        rt[s+1] <= {rt[s][OW-2:0], ge};
        tg[s+1] <= tg[s];
      end
    end
  end

  assign valid_o = vld[OW];
  assign root_o  = rt[OW];
  assign tag_o   = tg[OW];
endmodule

/* sv/gcfa_front.sv */
module gcfa_front #(
  parameter int unsigned FRAC_BITS = 10,
  parameter int unsigned ITEM_W    = 127
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gcfa_pkg::cfg_t    cfg_i,
  input  logic              push,
  output logic              full,
  input  logic              has_leader_i,
  input  logic [15:0]       own_speed_i,
  input  logic [19:0]       gap_i,
  input  logic [15:0]       leader_speed_i,
  input  logic              mid_ready_i,
  output logic              mid_push_o,
  output logic [ITEM_W-1:0] mid_item_o
);
  import gcfa_pkg::*;

  localparam int unsigned DISTW = FRAC_BITS + 22;

  logic              f_valid_q;
  logic              adv;
  logic [11:0]       tau_s;
  logic [27:0]       vtau_d;
  logic signed [27:0] bt_d;
  logic [31:0]       nsq_d;
  logic signed [20:0] diff_d;
  logic signed [DISTW-1:0] dist_d;

  logic              lead_q;
  logic [15:0]       v_q;
  logic [31:0]       nsq_q;
  logic [27:0]       vtau_q;
  logic signed [27:0] bt_q;
  logic signed [DISTW-1:0] dist_q;

  assign tau_s  = (cfg_i.reaction_time == '0) ? 12'd1 : cfg_i.reaction_time;
  assign vtau_d = own_speed_i * tau_s;
  assign bt_d   = $signed(cfg_i.max_decel) * $signed({1'b0, tau_s});
  assign nsq_d  = leader_speed_i * leader_speed_i;
  assign diff_d = $signed({1'b0, gap_i}) - $signed({5'b0, cfg_i.standstill_spacing});
  assign dist_d = DISTW'(diff_d) <<< (FRAC_BITS + 1);

  assign adv        = !f_valid_q || mid_ready_i;
  assign full       = !adv;
  assign mid_push_o = f_valid_q && mid_ready_i;
  assign mid_item_o = {lead_q, v_q, nsq_q, vtau_q, bt_q, dist_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (adv) begin
      f_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && push) begin
      lead_q <= has_leader_i;
      v_q    <= own_speed_i;
      nsq_q  <= nsq_d;
      vtau_q <= vtau_d;
      bt_q   <= bt_d;
      dist_q <= dist_d;
    end
  end
endmodule

/* sv/gcfa_back.sv */
module gcfa_back #(
  parameter int unsigned FRAC_BITS = 10,
  parameter int unsigned ITEM_W    = 127
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gcfa_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  input  logic [ITEM_W-1:0]  in_item_i,
  output logic               in_pop_o,
  input  logic               out_ready_i,
  output logic               out_push_o,
  output logic signed [15:0] acc_o,
  output logic               inv_o
);
  import gcfa_pkg::*;

  localparam int unsigned DISTW = FRAC_BITS + 22;
  localparam int unsigned NQW   = FRAC_BITS + 32;
  localparam int unsigned T1W   = DISTW + 74;
  localparam int unsigned XW    = NQW + 3;
  localparam int unsigned RW    = XW + 16;
  localparam int unsigned OW2   = RW / 2;
  localparam int unsigned MAGW  = (OW2 > FRAC_BITS + 16) ? OW2 : FRAC_BITS + 16;
  localparam int unsigned OW1   = 25;

  logic en;
  assign en       = out_ready_i;
  assign in_pop_o = en && in_valid_i;

  // static configuration, sanitized
  logic [11:0]       tau_s;
  logic [15:0]       vdes_s;
  logic signed [14:0] bh_s;
  logic [15:0]       bh_mag;
  logic              bh_neg;
  assign tau_s  = (cfg_i.reaction_time == '0) ? 12'd1 : cfg_i.reaction_time;
  assign vdes_s = (cfg_i.desired_speed == '0) ? 16'd1 : cfg_i.desired_speed;
  assign bh_s   = (cfg_i.leader_decel_estimate == '0) ? -15'sd1 : cfg_i.leader_decel_estimate;
  assign bh_neg = bh_s[14];
  assign bh_mag = bh_neg ? (16'd0 - {bh_s[14], bh_s}) : {1'b0, bh_s};

  // item from the front
  logic              i_lead;
  logic [15:0]       i_v;
  logic [31:0]       i_nsq;
  logic [27:0]       i_vtau;
  logic [27:0]       i_bt;
  logic [DISTW-1:0]  i_dist;
  assign {i_lead, i_v, i_nsq, i_vtau, i_bt, i_dist} = in_item_i;

  // leader speed term: (vl^2 << F) / |bh|
  logic              d1_valid;
  logic [NQW-1:0]    d1_quo;
  logic [14:0]       d1_rem;
  logic [T1W-1:0]    d1_tag;
  gcfa_div #(.NW(NQW), .DW(15), .TW(T1W)) u_div_lq (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .dvd_i({i_nsq, FRAC_BITS'(0)}), .dvs_i(bh_mag[14:0]),
    .tag_i({i_lead, i_v, i_vtau, i_bt, i_dist, bh_neg}),
    .valid_o(d1_valid), .quo_o(d1_quo), .rem_o(d1_rem), .tag_o(d1_tag)
  );

  logic              t1_lead;
  logic [15:0]       t1_v;
  logic [27:0]       t1_vtau;
  logic signed [27:0] t1_bt;
  logic signed [DISTW-1:0] t1_dist;
  logic              t1_neg;
  logic signed [NQW:0] lq;
  logic signed [XW-1:0] x_d;
  logic signed [55:0] bt2_d;
  assign {t1_lead, t1_v, t1_vtau, t1_bt, t1_dist, t1_neg} = d1_tag;
  assign lq    = t1_neg ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});
  assign x_d   = XW'(t1_dist) - XW'($signed({1'b0, t1_vtau})) - XW'(lq);
  assign bt2_d = t1_bt * t1_bt;

  logic              xs_valid_q, xs_lead_q;
  logic [15:0]       xs_v_q;
  logic signed [XW-1:0] xs_x_q;
  logic signed [55:0] xs_bt2_q;

  // radicand
  logic signed [XW+14:0] bx;
  logic signed [RW-1:0]  rad_d;
  assign bx    = $signed(cfg_i.max_decel) * xs_x_q;
  assign rad_d = RW'($signed({1'b0, xs_bt2_q})) - RW'(bx);

  logic              rs_valid_q, rs_lead_q, rs_neg_q;
  logic [15:0]       rs_v_q;
  logic signed [RW-1:0] rs_rad_q;

  logic              s2_valid;
  logic [OW2-1:0]    s2_root;
  logic [17:0]       s2_tag;
  gcfa_sqrt #(.OW(OW2), .TW(18)) u_sqrt_brk (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rs_valid_q),
    .rad_i(rs_neg_q ? '0 : rs_rad_q[2*OW2-1:0]),
    .tag_i({rs_lead_q, rs_v_q, rs_neg_q}),
    .valid_o(s2_valid), .root_o(s2_root), .tag_o(s2_tag)
  );

  logic              t2_lead, t2_neg;
  logic [15:0]       t2_v;
  logic signed [MAGW:0] num_d;
  assign {t2_lead, t2_v, t2_neg} = s2_tag;
  assign num_d = (MAGW+1)'($signed({1'b0, s2_root}))
               - (MAGW+1)'($signed({1'b0, t2_v, FRAC_BITS'(0)}));

  logic              ns_valid_q, ns_lead_q, ns_neg_q, ns_sgn_q;
  logic [15:0]       ns_v_q;
  logic [MAGW-1:0]   ns_mag_q;
  logic signed [MAGW:0] num_abs;
  assign num_abs = num_d[MAGW] ? -num_d : num_d;

  logic              d3_valid;
  logic [MAGW-1:0]   d3_quo;
  logic [11:0]       d3_rem;
  logic [18:0]       d3_tag;
  gcfa_div #(.NW(MAGW), .DW(12), .TW(19)) u_div_tau (
    .clk_i, .rst_ni, .en_i(en), .valid_i(ns_valid_q),
    .dvd_i(ns_mag_q), .dvs_i(tau_s),
    .tag_i({ns_lead_q, ns_v_q, ns_neg_q, ns_sgn_q}),
    .valid_o(d3_valid), .quo_o(d3_quo), .rem_o(d3_rem), .tag_o(d3_tag)
  );

  logic              t3_lead, t3_neg, t3_sgn;
  logic [15:0]       t3_v;
  logic signed [MAGW+1:0] qf;
  logic signed [MAGW+2:0] acc2_d;
  assign {t3_lead, t3_v, t3_neg, t3_sgn} = d3_tag;
  // floor for a negative numerator: round the magnitude up
  assign qf = t3_sgn ? -$signed({2'b0, d3_quo} + (MAGW+2)'(d3_rem != '0))
                     : $signed({2'b0, d3_quo});
  assign acc2_d = (MAGW+3)'($signed(cfg_i.max_decel)) + (MAGW+3)'(qf);

  logic              a2_valid_q, a2_lead_q, a2_neg_q;
  logic [15:0]       a2_v_q;
  logic signed [15:0] a2_acc2_q;

  // speed ratio v/V in Q16
  logic              d4_valid;
  logic [31:0]       d4_quo;
  logic [15:0]       d4_rem;
  logic [17:0]       d4_tag;
  gcfa_div #(.NW(32), .DW(16), .TW(18)) u_div_ratio (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a2_valid_q),
    .dvd_i({a2_v_q, 16'd0}), .dvs_i(vdes_s),
    .tag_i({a2_lead_q, a2_neg_q, a2_acc2_q}),
    .valid_o(d4_valid), .quo_o(d4_quo), .rem_o(d4_rem), .tag_o(d4_tag)
  );

  logic signed [33:0] om_d;
  logic [48:0]       sarg_d;
  assign om_d   = 34'sd65536 - $signed({2'b0, d4_quo});
  assign sarg_d = {({1'b0, d4_quo} + Q16_0025), 16'd0};

  logic              ss_valid_q;
  logic [17:0]       ss_tag_q;
  logic signed [33:0] ss_om_q;
  logic [48:0]       ss_sarg_q;

  logic              s1_valid;
  logic [OW1-1:0]    s1_root;
  logic [51:0]       s1_tag;
  gcfa_sqrt #(.OW(OW1), .TW(52)) u_sqrt_free (
    .clk_i, .rst_ni, .en_i(en), .valid_i(ss_valid_q),
    .rad_i({1'b0, ss_sarg_q}), .tag_i({ss_tag_q, ss_om_q}),
    .valid_o(s1_valid), .root_o(s1_root), .tag_o(s1_tag)
  );

  logic [17:0]       t5_tag;
  logic signed [33:0] t5_om;
  logic signed [59:0] pprod;
  assign {t5_tag, t5_om} = s1_tag;
  assign pprod = t5_om * $signed({1'b0, s1_root});

  logic              ps_valid_q;
  logic [17:0]       ps_tag_q;
  logic signed [43:0] ps_p_q;

  logic [16:0]       a5;
  logic signed [61:0] aprod;
  logic signed [44:0] acc1_d;
  assign a5     = {1'b0, cfg_i.max_accel, 2'b0} + {3'b0, cfg_i.max_accel};
  assign aprod  = ps_p_q * $signed({1'b0, a5});
  assign acc1_d = aprod[61:17];

  logic              as_valid_q;
  logic [17:0]       as_tag_q;
  logic signed [15:0] as_acc1_q;

  logic              f_lead, f_neg;
  logic signed [15:0] f_acc2;
  logic signed [15:0] fin_acc;
  assign {f_lead, f_neg, f_acc2} = as_tag_q;

  // saturation is monotonic, so the minimum of saturated candidates matches
  always_comb begin
    priority if (!f_lead) begin
      fin_acc = $signed({2'b0, cfg_i.max_accel});
    end else if (f_neg) begin
      fin_acc = as_acc1_q;
    end else begin
      fin_acc = (f_acc2 < as_acc1_q) ? f_acc2 : as_acc1_q;
    end
  end

  logic              o_valid_q;
  assign out_push_o = en && o_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_valid_q <= 1'b0;
      rs_valid_q <= 1'b0;
      ns_valid_q <= 1'b0;
      a2_valid_q <= 1'b0;
      ss_valid_q <= 1'b0;
      ps_valid_q <= 1'b0;
      as_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else if (en) begin
      xs_valid_q <= d1_valid;
      rs_valid_q <= xs_valid_q;
      ns_valid_q <= s2_valid;
      a2_valid_q <= d3_valid;
      ss_valid_q <= d4_valid;
      ps_valid_q <= s1_valid;
      as_valid_q <= ps_valid_q;
      o_valid_q  <= as_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xs_lead_q <= t1_lead;
      xs_v_q    <= t1_v;
      xs_x_q    <= x_d;
      xs_bt2_q  <= bt2_d;

      rs_lead_q <= xs_lead_q;
      rs_v_q    <= xs_v_q;
      rs_rad_q  <= rad_d;
      rs_neg_q  <= rad_d[RW-1];

      ns_lead_q <= t2_lead;
      ns_v_q    <= t2_v;
      ns_neg_q  <= t2_neg;
      ns_sgn_q  <= num_d[MAGW];
      ns_mag_q  <= num_abs[MAGW-1:0];

      a2_lead_q <= t3_lead;
      a2_v_q    <= t3_v;
      a2_neg_q  <= t3_neg;
      a2_acc2_q <= sat16(64'(acc2_d));

      ss_tag_q  <= d4_tag;
      ss_om_q   <= om_d;
      ss_sarg_q <= sarg_d;

      ps_tag_q  <= t5_tag;
      ps_p_q    <= pprod[59:16];

      as_tag_q  <= ps_tag_q;
      as_acc1_q <= sat16(64'(acc1_d));

      acc_o     <= fin_acc;
      inv_o     <= f_lead && f_neg;
    end
  end
endmodule

/* sv/gipps_car_following_accel.sv */
// Gipps car-following acceleration, one vehicle per item, no state kept
// between vehicles.
// Input side is a queue write port: an item (has_leader, own_speed, gap,
// leader_speed) transfers on a clock edge with push high and full low.
// Result side is a queue read port: while empty is low the oldest result
// (acceleration, braking_bound_invalid) is on the ports; it transfers on a
// clock edge with pop high.
// Parameters sit on a separate write channel (cfg_valid_i / cfg_ready_o,
// index and data); write them only while no item is in flight.
// Throughput: one item per cycle while the reader keeps up. The back end
// chains the bit-per-stage divider and square-root
// pipelines (leader term, braking root, divide by reaction time, speed
// ratio, free-flow root).
// If the reader stalls, the output queue fills, the back end freezes in
// place, the mid queue absorbs the front end, then full rises; nothing is
// dropped and flow resumes at full rate once pop returns.
// Reset empties both queues and all pipeline valid bits and loads the
// default parameter set.
module gipps_car_following_accel #(
  parameter int unsigned FRAC_BITS = gcfa_pkg::FRAC_BITS_DEF,
  parameter int unsigned QDEPTH    = gcfa_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           has_leader_i,
  input  logic [15:0]                    own_speed_i,
  input  logic [19:0]                    gap_i,
  input  logic [15:0]                    leader_speed_i,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [15:0]             acceleration_o,
  output logic                           braking_bound_invalid_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gcfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gcfa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gcfa_pkg::*;

  localparam int unsigned ITEM_W = FRAC_BITS + 127;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_accel             <= RST_MAX_ACCEL;
      cfg_q.max_decel             <= RST_MAX_DECEL;
      cfg_q.desired_speed         <= RST_DESIRED_SPEED;
      cfg_q.reaction_time         <= RST_REACTION_TIME;
      cfg_q.standstill_spacing    <= RST_STANDSTILL;
      cfg_q.leader_decel_estimate <= RST_LEADER_DECEL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MAX_ACCEL:     cfg_q.max_accel             <= cfg_data_i[13:0];
        CFG_MAX_DECEL:     cfg_q.max_decel             <= cfg_data_i[14:0];
        CFG_DESIRED_SPEED: cfg_q.desired_speed         <= cfg_data_i;
        CFG_REACTION_TIME: cfg_q.reaction_time         <= cfg_data_i[11:0];
        CFG_STANDSTILL:    cfg_q.standstill_spacing    <= cfg_data_i;
        CFG_LEADER_DECEL:  cfg_q.leader_decel_estimate <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic              mid_push, mid_full, mid_empty, mid_pop;
  logic [ITEM_W-1:0] mid_wdata, mid_rdata;

  gcfa_front #(.FRAC_BITS(FRAC_BITS), .ITEM_W(ITEM_W)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .push, .full,
    .has_leader_i, .own_speed_i, .gap_i, .leader_speed_i,
    .mid_ready_i(!mid_full), .mid_push_o(mid_push), .mid_item_o(mid_wdata)
  );

  gcfa_fifo #(.W(ITEM_W), .DEPTH(QDEPTH)) u_mid_q (
    .clk_i, .rst_ni, .push_i(mid_push), .data_i(mid_wdata),
    .pop_i(mid_pop), .data_o(mid_rdata), .empty_o(mid_empty), .full_o(mid_full)
  );

  logic              res_push, res_full, res_inv;
  logic signed [15:0] res_acc;

  gcfa_back #(.FRAC_BITS(FRAC_BITS), .ITEM_W(ITEM_W)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(!mid_empty), .in_item_i(mid_rdata), .in_pop_o(mid_pop),
    .out_ready_i(!res_full || pop), .out_push_o(res_push),
    .acc_o(res_acc), .inv_o(res_inv)
  );

  gcfa_fifo #(.W(17), .DEPTH(QDEPTH)) u_res_q (
    .clk_i, .rst_ni, .push_i(res_push), .data_i({res_acc, res_inv}),
    .pop_i(pop), .data_o({acceleration_o, braking_bound_invalid_o}),
    .empty_o(empty), .full_o(res_full)
  );
endmodule

/* sv/gcfa_checker.sv */
`include "gipps_car_following_accel_macros.svh"

module gcfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic signed [15:0]             acceleration_o,
  input logic                           braking_bound_invalid_o
);
  // queues come up empty and open
  `GCFA_ASSERT_RST(a_reset_quiet, !rst_ni |-> empty && !full, "reset leaves data or backpressure")

  // a waiting result holds until it transfers
  `GCFA_ASSERT(a_result_hold, !empty && !pop |=> !empty && $stable(acceleration_o) && $stable(braking_bound_invalid_o), "waiting result changed")

  // input backpressure only builds up behind a stalled reader
  `GCFA_ASSERT(a_full_cause, $rose(full) |-> $past(!empty && !pop), "full rose without a stalled reader")
endmodule

bind gipps_car_following_accel gcfa_checker u_gcfa_checker (.*);

/* tb/tb_gipps_car_following_accel.sv */
module tb_gipps_car_following_accel;
  timeunit 1ns;
  timeprecision 1ps;

  import gcfa_pkg::*;

  localparam int unsigned RAND_PER_PHASE = 94;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned DRAIN_CYCLES   = 400;
  localparam longint     CYCLE_LIMIT     = 600000;

  typedef struct {
    logic signed [15:0] accel;
    logic               invalid;
  } accel_result_t;

  class accel_scoreboard;
    cfg_t          regs;
    accel_result_t pending[$];
    int unsigned   errors;

    function new();
      regs.max_accel             = RST_MAX_ACCEL;
      regs.max_decel             = RST_MAX_DECEL;
      regs.desired_speed         = RST_DESIRED_SPEED;
      regs.reaction_time         = RST_REACTION_TIME;
      regs.standstill_spacing    = RST_STANDSTILL;
      regs.leader_decel_estimate = RST_LEADER_DECEL;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] d);
      case (idx)
        CFG_MAX_ACCEL:     regs.max_accel = d[13:0];
        CFG_MAX_DECEL:     regs.max_decel = d[14:0];
        CFG_DESIRED_SPEED: regs.desired_speed = d;
        CFG_REACTION_TIME: regs.reaction_time = d[11:0];
        CFG_STANDSTILL:    regs.standstill_spacing = d;
        CFG_LEADER_DECEL:  regs.leader_decel_estimate = d[14:0];
        default: ;
      endcase
    endfunction

    static function longint unsigned floor_root(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Compute the commanded acceleration for one vehicle and queue it.
    function void note_vehicle(logic lead, logic [15:0] v_in, logic [19:0] gap_in,
                               logic [15:0] vl_in);
      longint unsigned vdes, ratio, vl_sq;
      longint v, gapd, vl, tau, b, bh, one, om, q1, p, acc1, bt, spacing, lq, x, rad;
      longint q2, num, quo, acc2, acc;
      accel_result_t res;
      res.invalid = 1'b0;
      one = longint'(1) << FRAC_BITS_DEF;
      v = longint'({48'd0, v_in});
      gapd = longint'({44'd0, gap_in});
      vl = longint'({48'd0, vl_in});
      if (!lead) begin
        acc = longint'({50'd0, regs.max_accel});
      end else begin
        vdes = (regs.desired_speed != 0) ? {48'd0, regs.desired_speed} : 64'd1;
        tau = (regs.reaction_time != 0) ? longint'({52'd0, regs.reaction_time}) : 1;
        b = regs.max_decel;
        bh = (regs.leader_decel_estimate != 0) ? longint'(regs.leader_decel_estimate) : -1;
        ratio = ({48'd0, v_in} << 16) / vdes;
        om = 65536 - longint'(ratio);
        q1 = longint'(floor_root((ratio + 64'd1638) << 16));
        p = (om * q1) >>> 16;
        acc1 = (p * 5 * longint'({50'd0, regs.max_accel})) >>> 17;
        bt = b * tau;
        spacing = (gapd - longint'({48'd0, regs.standstill_spacing})) * 2 * one;
        vl_sq = {48'd0, vl_in} * {48'd0, vl_in};
        lq = (longint'(vl_sq) * one) / bh;
        x = spacing - v * tau - lq;
        rad = bt * bt - b * x;
        if (rad < 0) begin
          acc = acc1;
          res.invalid = 1'b1;
        end else begin
          q2 = longint'(floor_root(rad));
          num = q2 - v * one;
          quo = num / tau;
          if ((num % tau) != 0 && num < 0) quo -= 1;
          acc2 = b + quo;
          acc = (acc2 < acc1) ? acc2 : acc1;
        end
      end
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      res.accel = acc[15:0];
      pending.push_back(res);
    endfunction

    function void check_result(logic signed [15:0] accel, logic invalid);
      accel_result_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result: acceleration %0d invalid %0b", accel, invalid);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (accel !== exp_res.accel) begin
        $error("acceleration: expected %0d, got %0d", exp_res.accel, accel);
        errors++;
      end
      if (invalid !== exp_res.invalid) begin
        $error("braking_bound_invalid: expected %0b, got %0b", exp_res.invalid, invalid);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push = 1'b0;
  logic               full;
  logic               has_leader_i = 1'b0;
  logic [15:0]        own_speed_i = '0;
  logic [19:0]        gap_i = '0;
  logic [15:0]        leader_speed_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] acceleration_o;
  logic               braking_bound_invalid_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  cfg_idx_e           cfg_index_i = CFG_MAX_ACCEL;
  logic [15:0]        cfg_data_i = '0;

  accel_scoreboard sb = new();
  int unsigned     idle_pct = 0;
  int unsigned     stall_pct = 0;
  longint          cycles = 0;

  gipps_car_following_accel DUT (
    .clk_i, .rst_ni, .push, .full, .has_leader_i, .own_speed_i, .gap_i,
    .leader_speed_i, .empty, .pop, .acceleration_o, .braking_bound_invalid_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, check every transfer.
  initial begin
    forever begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
      @(posedge clk_i);
      if (rst_ni && pop && !empty) sb.check_result(acceleration_o, braking_bound_invalid_o);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [15:0] a, logic [15:0] b, logic [15:0] vd,
                           logic [15:0] t, logic [15:0] s, logic [15:0] bh);
    write_reg(CFG_MAX_ACCEL, a);
    write_reg(CFG_MAX_DECEL, b);
    write_reg(CFG_DESIRED_SPEED, vd);
    write_reg(CFG_REACTION_TIME, t);
    write_reg(CFG_STANDSTILL, s);
    write_reg(CFG_LEADER_DECEL, bh);
  endtask

  task automatic send_vehicle(logic lead, logic [15:0] v, logic [19:0] g, logic [15:0] vl);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    has_leader_i   <= lead;
    own_speed_i    <= v;
    gap_i          <= g;
    leader_speed_i <= vl;
    do @(posedge clk_i); while (full);
    sb.note_vehicle(lead, v, g, vl);
  endtask

  task automatic send_random();
    logic [15:0] v, vl;
    logic [19:0] g;
    // Keep most traffic plausible so both bounds get exercised.
    if ($urandom_range(0, 3) == 0) begin
      v = 16'($urandom);
      vl = 16'($urandom);
      g = 20'($urandom);
    end else begin
      v = 16'($urandom_range(0, 40000));
      vl = 16'($urandom_range(0, 40000));
      g = 20'($urandom_range(0, 200000));
    end
    send_vehicle($urandom_range(0, 9) != 0, v, g, vl);
  endtask

  task automatic send_directed();
    send_vehicle(1'b0, 16'hffff, 20'hfffff, 16'hffff);
    send_vehicle(1'b0, 16'd0, 20'd0, 16'd0);
    send_vehicle(1'b1, 16'd0, 20'd0, 16'd0);
    send_vehicle(1'b1, 16'hffff, 20'd0, 16'd0);
    send_vehicle(1'b1, 16'hffff, 20'hfffff, 16'hffff);
    send_vehicle(1'b1, 16'd0, 20'hfffff, 16'hffff);
    send_vehicle(1'b1, 16'd20480, 20'd30720, 16'd20480);
    send_vehicle(1'b1, 16'd30000, 20'd1000, 16'd0);
    send_vehicle(1'b1, 16'd5000, 20'd500000, 16'd5000);
    send_vehicle(1'b1, 16'h5555, 20'haaaaa, 16'haaaa);
    send_vehicle(1'b1, 16'haaaa, 20'h55555, 16'h5555);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      case (ph)
        0: ;
        1: write_all(16'd16383, 16'h4000, 16'd65535, 16'd4095, 16'd65535, 16'h4000);
        2: write_all(16'd1, 16'h7fff, 16'd1, 16'd1, 16'd0, 16'h7fff);
        // zero and positive settings, plus stray bits above the field widths
        3: write_all(16'hc000 | 16'd100, 16'd2000, 16'd0, 16'hf000, 16'd1024, 16'd0);
        4: write_all(16'd3000, 16'hb000, 16'd30000, 16'd1024, 16'd5000, 16'h3000);
        default: write_all(16'($urandom_range(1, 16383)), 16'(-$urandom_range(1, 16384)),
                           16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4095)),
                           16'($urandom), 16'(-$urandom_range(1, 16384)));
      endcase
      if (ph < 4) send_directed();
      for (int i = 0; i < RAND_PER_PHASE; i++) send_random();
      drain();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* gipps_car_following_accel.f */
+incdir+sv
sv/gcfa_pkg.sv
sv/gcfa_fifo.sv
sv/gcfa_div.sv
sv/gcfa_sqrt.sv
sv/gcfa_front.sv
sv/gcfa_back.sv
sv/gipps_car_following_accel.sv
sv/gcfa_checker.sv
tb/tb_gipps_car_following_accel.sv
